FILE: src/sadf_pkg.sv
// Shared constants, register indexes and helper functions for the sphere air drag block.
// No dependencies.
package sadf_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int CONST_BITS = 30;

    localparam logic [34:0] PI6 = 35'd20239556557;
    localparam logic [34:0] PI8 = 35'd26986075409;
    localparam logic [29:0] PIQ = 30'd843314857;

    localparam int CW  = 32 + FRAC_BITS;
    localparam logic [CW-1:0] COEF_LIM = CW'(1) << (31 + FRAC_BITS);

    localparam logic [2:0] REG_VISCOSITY     = 3'd0;
    localparam logic [2:0] REG_DENSITY       = 3'd1;
    localparam logic [2:0] REG_WIND_X        = 3'd2;
    localparam logic [2:0] REG_WIND_Y        = 3'd3;
    localparam logic [2:0] REG_WIND_Z        = 3'd4;
    localparam logic [2:0] REG_GROUP_SELECT  = 3'd5;
    localparam logic [2:0] REG_REGION_ENABLE = 3'd6;

    typedef struct packed {
        logic             sel;
        logic [2:0][32:0] vr_mag;
        logic [2:0]       vr_neg;
        logic [2:0][31:0] sp_mag;
        logic [2:0]       sp_pos;
    } side_t;

    function automatic logic [CW-1:0] coef_limit(input logic [96:0] x);
        if (x > 97'(COEF_LIM))
            return COEF_LIM;
        return x[CW-1:0];
    endfunction

    function automatic logic [31:0] sat_term(input logic [80:0] prod, input logic neg);
        logic [80:0] m;
        m = prod >> FRAC_BITS;
        if (neg)
        begin
            if (m >= 81'h8000_0000)
                return 32'h8000_0000;
            return 32'd0 - m[31:0];
        end
        if (m >= 81'h7fff_ffff)
            return 32'h7fff_ffff;
        return m[31:0];
    endfunction

endpackage

FILE: src/sadf_mul.sv
// Two-stage unsigned multiplier: 32-bit slices of a times b, then the shifted sum.
// Depends on nothing.
module sadf_mul #(
    parameter int AW = 62,
    parameter int BW = 35
) (
    input  logic                clk,
    input  logic                en,
    input  logic [AW-1:0]       a,
    input  logic [BW-1:0]       b,
    output logic [AW+BW-1:0]    p
);
    localparam int NC = (AW + 31) / 32;
    localparam int PW = 32 + BW;
    localparam int SW = NC * 32 + BW;

    logic [NC*32-1:0] a_pad;
    logic [PW-1:0]    pp_reg [NC];
    logic [SW-1:0]    sum_next;
    logic [AW+BW-1:0] p_reg;

    assign a_pad = (NC*32)'(a);

    always_comb
    begin
        sum_next = '0;
        for (int k = 0; k < NC; k++)
            sum_next = sum_next + (SW'(pp_reg[k]) << (32 * k));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NC; k++)
                pp_reg[k] <= PW'(a_pad[k*32 +: 32]) * PW'(b);
            p_reg <= sum_next[AW+BW-1:0];
        end
    end

    assign p = p_reg;

endmodule

FILE: src/sadf_isqrt.sv
// Pipelined integer square root, one result bit per stage, 34 stages.
// Depends on nothing.
module sadf_isqrt (
    input  logic        clk,
    input  logic        en,
    input  logic [65:0] s,
    output logic [33:0] root
);
    localparam int NS = 34;

    logic [34:0] rem_reg  [NS];
    logic [33:0] root_reg [NS];
    logic [67:0] sv_reg   [NS];

    genvar k;
    generate
        for (k = 0; k < NS; k++)
        begin : g_stage
            logic [34:0] in_rem;
            logic [33:0] in_root;
            logic [67:0] in_s;
            logic [36:0] cur;
            logic [36:0] trial;
            logic        ge;

            if (k == 0)
            begin : g_first
                assign in_rem  = '0;
                assign in_root = '0;
                assign in_s    = {2'b00, s};
            end
            else
            begin : g_next
                assign in_rem  = rem_reg[k-1];
                assign in_root = root_reg[k-1];
                assign in_s    = sv_reg[k-1];
            end

            assign cur   = {in_rem, in_s[67:66]};
            assign trial = {1'b0, in_root, 2'b01};
            assign ge    = (cur >= trial);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]  <= ge ? 35'(cur - trial) : cur[34:0];
                    root_reg[k] <= {in_root[32:0], ge};
                    sv_reg[k]   <= {in_s[65:0], 2'b00};
                end
            end
        end
    endgenerate

    assign root = root_reg[NS-1];

endmodule

FILE: src/sphere_air_drag_force_torque.sv
// Sphere air drag: Stokes plus quadratic drag force and viscous spin torque per beat.
// Depends on sadf_pkg, sadf_mul and sadf_isqrt.
// One beat accepted every cycle unless the skid entry holds a result.
// Latency is set mostly by the 34-stage square root of the squared relative speed.
// A two-entry output (register plus skid) lets the pipeline run while a result waits.
// Reset (rst_n low, asynchronous) clears all valid bits and the configuration to zero.
module sphere_air_drag_force_torque
    import sadf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // vel_x, vel_y, vel_z, spin_x, spin_y, spin_z, particle_radius, group_bits, pad
    input  logic [255:0] s_tdata,
    // in_region
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // force_x, force_y, force_z, torque_x, torque_y, torque_z
    output logic [191:0] m_tdata,
    // applied
    output logic         m_tuser
);
    localparam int LAT = 43;

    logic [30:0] viscosity_reg, density_reg;
    logic [31:0] wind_x_reg, wind_y_reg, wind_z_reg, group_select_reg;
    logic        region_enable_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            viscosity_reg     <= '0;
            density_reg       <= '0;
            wind_x_reg        <= '0;
            wind_y_reg        <= '0;
            wind_z_reg        <= '0;
            group_select_reg  <= '0;
            region_enable_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_VISCOSITY:     viscosity_reg     <= cfg_wdata[30:0];
                REG_DENSITY:       density_reg       <= cfg_wdata[30:0];
                REG_WIND_X:        wind_x_reg        <= cfg_wdata;
                REG_WIND_Y:        wind_y_reg        <= cfg_wdata;
                REG_WIND_Z:        wind_z_reg        <= cfg_wdata;
                REG_GROUP_SELECT:  group_select_reg  <= cfg_wdata;
                REG_REGION_ENABLE: region_enable_reg <= cfg_wdata[0];
                default:           ;
            endcase
        end
    end

    logic en;
    logic skid_valid_reg;
    logic vld_reg [LAT];

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // stage 1: relative velocity, magnitudes, selection
    side_t       side_next, side1_reg;
    logic [30:0] r1_reg;
    logic [31:0] wind [3];

    assign wind[0] = wind_x_reg;
    assign wind[1] = wind_y_reg;
    assign wind[2] = wind_z_reg;

    always_comb
    begin
        logic [32:0] vr;
        logic [31:0] sp;
        side_next.sel = ((s_tdata[254:223] & group_select_reg) != 32'd0) &&
                        (!region_enable_reg || s_tuser);
        for (int i = 0; i < 3; i++)
        begin
            vr = {wind[i][31], wind[i]} - {s_tdata[32*i+31], s_tdata[32*i +: 32]};
            side_next.vr_neg[i] = vr[32];
            side_next.vr_mag[i] = vr[32] ? 33'd0 - vr : vr;
            sp = s_tdata[96+32*i +: 32];
            side_next.sp_pos[i] = !sp[31] && (sp != 32'd0);
            side_next.sp_mag[i] = sp[31] ? 32'd0 - sp : sp;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side1_reg <= side_next;
            r1_reg    <= s_tdata[222:192];
        end
    end

    // stage 2: squares and first coefficient products
    logic [65:0] sq2_reg [3];
    logic [61:0] vp2_reg, dr2_reg;
    logic [30:0] r2_reg;
    logic [65:0] s3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                sq2_reg[i] <= 66'(side1_reg.vr_mag[i]) * 66'(side1_reg.vr_mag[i]);
            vp2_reg <= 62'(viscosity_reg) * 62'(r1_reg);
            dr2_reg <= 62'(density_reg) * 62'(r1_reg);
            r2_reg  <= r1_reg;
            s3_reg  <= sq2_reg[0] + sq2_reg[1] + sq2_reg[2];
        end
    end

    logic [33:0] nrm;
    sadf_isqrt u_isqrt (.clk(clk), .en(en), .s(s3_reg), .root(nrm));

    logic [96:0]  b_prod;
    logic [92:0]  c1_prod, d1_prod;
    logic [122:0] c2_prod;
    logic [127:0] d2_prod;
    logic [96:0]  d3_prod;
    logic [94:0]  cn_prod;

    sadf_mul #(.AW(62), .BW(35)) u_mul_b
        (.clk(clk), .en(en), .a(vp2_reg), .b(PI6), .p(b_prod));
    sadf_mul #(.AW(62), .BW(31)) u_mul_c1
        (.clk(clk), .en(en), .a(dr2_reg), .b(r2_reg), .p(c1_prod));
    sadf_mul #(.AW(93), .BW(30)) u_mul_c2
        (.clk(clk), .en(en), .a(c1_prod), .b(PIQ), .p(c2_prod));
    sadf_mul #(.AW(62), .BW(31)) u_mul_d1
        (.clk(clk), .en(en), .a(vp2_reg), .b(r2_reg), .p(d1_prod));
    sadf_mul #(.AW(93), .BW(35)) u_mul_d2
        (.clk(clk), .en(en), .a(d1_prod), .b(PI8), .p(d2_prod));

    logic [30:0] r_dly_reg [4];
    sadf_mul #(.AW(66), .BW(31)) u_mul_d3
        (.clk(clk), .en(en), .a(d2_prod[127:62]), .b(r_dly_reg[3]), .p(d3_prod));

    logic [CW-1:0] d9_reg;
    logic [CW-1:0] d_dly_reg  [31];
    logic [60:0]   cq_dly_reg [31];
    logic [50:0]   b_dly_reg  [35];
    side_t         side_dly_reg [41];
    logic [CW-1:0] t40_reg;

    sadf_mul #(.AW(61), .BW(34)) u_mul_cn
        (.clk(clk), .en(en), .a(cq_dly_reg[30]), .b(nrm), .p(cn_prod));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_dly_reg[0]    <= r2_reg;
            d_dly_reg[0]    <= d9_reg;
            cq_dly_reg[0]   <= c2_prod[122:62];
            b_dly_reg[0]    <= b_prod[96:46];
            side_dly_reg[0] <= side1_reg;
            for (int k = 1; k < 4; k++)
                r_dly_reg[k] <= r_dly_reg[k-1];
            for (int k = 1; k < 31; k++)
            begin
                d_dly_reg[k]  <= d_dly_reg[k-1];
                cq_dly_reg[k] <= cq_dly_reg[k-1];
            end
            for (int k = 1; k < 35; k++)
                b_dly_reg[k] <= b_dly_reg[k-1];
            for (int k = 1; k < 41; k++)
                side_dly_reg[k] <= side_dly_reg[k-1];
            d9_reg  <= coef_limit(97'(d3_prod[96:16]));
            t40_reg <= coef_limit(97'(b_dly_reg[34]) + 97'(cn_prod[94:16]));
        end
    end

    // final products and saturation
    logic [80:0] f_prod [3];
    logic [79:0] q_prod [3];

    genvar g;
    generate
        for (g = 0; g < 3; g++)
        begin : g_lane
            sadf_mul #(.AW(CW), .BW(33)) u_mul_f
                (.clk(clk), .en(en), .a(t40_reg),
                 .b(side_dly_reg[38].vr_mag[g]), .p(f_prod[g]));
            sadf_mul #(.AW(CW), .BW(32)) u_mul_q
                (.clk(clk), .en(en), .a(d_dly_reg[30]),
                 .b(side_dly_reg[38].sp_mag[g]), .p(q_prod[g]));
        end
    endgenerate

    logic [191:0] res_reg;
    logic         applied_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                res_reg[32*i +: 32] <= side_dly_reg[40].sel ?
                    sat_term(f_prod[i], side_dly_reg[40].vr_neg[i]) : 32'd0;
                res_reg[96+32*i +: 32] <= side_dly_reg[40].sel ?
                    sat_term(81'(q_prod[i]), side_dly_reg[40].sp_pos[i]) : 32'd0;
            end
            applied_reg <= side_dly_reg[40].sel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LAT; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= s_tvalid;
            for (int k = 1; k < LAT; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    // output register and skid beat
    logic         out_valid_reg;
    logic [191:0] out_data_reg, skid_data_reg;
    logic         out_user_reg, skid_user_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= vld_reg[LAT-1];
        end
        else if (vld_reg[LAT-1] && en)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_tready)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : res_reg;
            out_user_reg <= skid_valid_reg ? skid_user_reg : applied_reg;
        end
        else if (en)
        begin
            skid_data_reg <= res_reg;
            skid_user_reg <= applied_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    a_skid_only_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid beat held with empty output register");

    a_unapplied_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == 192'd0))
        else $error("non-applied beat carries nonzero increments");

    a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg[LAT-1]))
        else $error("pipeline advanced while stalled");

endmodule

FILE: dv/sadf_checker.sv
// Checker for the sphere air drag block: tracks register writes, predicts each result beat
// from every accepted input beat and compares it with the output channel.
// Depends on sadf_pkg for register indexes and the fixed-point widths.
module sadf_checker
    import sadf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [255:0] s_tdata,
    input  logic         s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [191:0] m_tdata,
    input  logic         m_tuser,
    output int           fail_count,
    output int           pending
);

    logic [30:0] visc;
    logic [30:0] dens;
    logic [31:0] wind [3];
    logic [31:0] grp_sel;
    logic        region_en;

    logic [191:0] drag_q [$];
    logic         applied_q [$];

    string field_name [6] = '{"force_x", "force_y", "force_z",
                              "torque_x", "torque_y", "torque_z"};

    function automatic logic [33:0] root_floor(input logic [67:0] s);
        logic [33:0] r;
        logic [33:0] cand;
        r = '0;
        for (int k = 33; k >= 0; k--)
        begin
            cand = r | (34'd1 << k);
            if (68'(cand) * 68'(cand) <= s)
                r = cand;
        end
        return r;
    endfunction

    function automatic logic [31:0] clamp_term(input logic [139:0] prod, input logic neg);
        logic [139:0] m;
        m = prod >> FRAC_BITS;
        if (neg)
        begin
            if (m >= 140'h8000_0000)
                return 32'h8000_0000;
            return 32'd0 - m[31:0];
        end
        if (m >= 140'h7fff_ffff)
            return 32'h7fff_ffff;
        return m[31:0];
    endfunction

    // returns {applied, torque_z .. force_x}
    function automatic logic [192:0] drag_result(input logic [255:0] d, input logic in_reg);
        logic [139:0] r;
        logic [139:0] vmag [3];
        logic         vneg [3];
        logic [139:0] smag [3];
        logic         spos [3];
        logic signed [33:0] vr;
        logic signed [31:0] sp;
        logic [139:0] sq;
        logic [139:0] nrm;
        logic [139:0] b;
        logic [139:0] c;
        logic [139:0] t;
        logic [139:0] d1;
        logic [139:0] dt;
        logic [139:0] lim;
        logic [192:0] res;
        res = '0;
        if ((d[254:223] & grp_sel) == 0 || (region_en && !in_reg))
            return res;
        r = 140'(d[222:192]);
        lim = 140'd1 << (31 + FRAC_BITS);
        sq = '0;
        for (int i = 0; i < 3; i++)
        begin
            vr = 34'(signed'(wind[i])) - 34'(signed'(d[32*i +: 32]));
            vneg[i] = vr < 0;
            vmag[i] = vneg[i] ? 140'(-vr) : 140'(vr);
            sq = sq + vmag[i] * vmag[i];
            sp = signed'(d[96 + 32*i +: 32]);
            spos[i] = sp > 0;
            smag[i] = sp < 0 ? 140'(-34'(sp)) : 140'(sp);
        end
        nrm = 140'(root_floor(sq[67:0]));
        b = (140'(visc) * r * 140'(PI6)) >> (CONST_BITS + FRAC_BITS);
        c = (140'(dens) * r * r * 140'(PIQ)) >> (CONST_BITS + 2 * FRAC_BITS);
        t = b + ((c * nrm) >> FRAC_BITS);
        if (t > lim)
            t = lim;
        d1 = (140'(visc) * r * r * 140'(PI8)) >> (CONST_BITS + 2 * FRAC_BITS);
        dt = (d1 * r) >> FRAC_BITS;
        if (dt > lim)
            dt = lim;
        for (int i = 0; i < 3; i++)
        begin
            res[32*i +: 32] = clamp_term(vmag[i] * t, vneg[i]);
            res[96 + 32*i +: 32] = clamp_term(smag[i] * dt, spos[i]);
        end
        res[192] = 1'b1;
        return res;
    endfunction

    assign pending = drag_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        logic [192:0] exp_res;
        logic [191:0] exp_data;
        int           errs;
        if (!rst_n)
        begin
            visc <= '0;
            dens <= '0;
            wind <= '{default: '0};
            grp_sel <= '0;
            region_en <= 1'b0;
            fail_count <= 0;
            drag_q.delete();
            applied_q.delete();
        end
        else
        begin
            errs = 0;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_VISCOSITY:     visc <= cfg_wdata[30:0];
                    REG_DENSITY:       dens <= cfg_wdata[30:0];
                    REG_WIND_X:        wind[0] <= cfg_wdata;
                    REG_WIND_Y:        wind[1] <= cfg_wdata;
                    REG_WIND_Z:        wind[2] <= cfg_wdata;
                    REG_GROUP_SELECT:  grp_sel <= cfg_wdata;
                    REG_REGION_ENABLE: region_en <= cfg_wdata[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                exp_res = drag_result(s_tdata, s_tuser);
                drag_q.push_back(exp_res[191:0]);
                applied_q.push_back(exp_res[192]);
            end
            if (m_tvalid && m_tready)
            begin
                if (drag_q.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    errs++;
                end
                else
                begin
                    exp_data = drag_q.pop_front();
                    if (applied_q[0] !== m_tuser)
                    begin
                        $error("applied: expected %0d, got %0d", applied_q[0], m_tuser);
                        errs++;
                    end
                    void'(applied_q.pop_front());
                    for (int i = 0; i < 6; i++)
                    begin
                        if (exp_data[32*i +: 32] !== m_tdata[32*i +: 32])
                        begin
                            $error("%s: expected %h, got %h", field_name[i],
                                   exp_data[32*i +: 32], m_tdata[32*i +: 32]);
                            errs++;
                        end
                    end
                end
            end
            fail_count <= fail_count + errs;
        end
    end

endmodule

FILE: dv/sphere_air_drag_force_torque_test.sv
// Testbench top for the sphere air drag block: drives register settings and particle beats
// with bursty input and a stalling output, and reports the verdict from sadf_checker.
// Depends on sadf_pkg, sadf_checker and the block itself.
module sphere_air_drag_force_torque_test;
    import sadf_pkg::*;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [2:0]   cfg_index;
    logic [31:0]  cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [255:0] s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [191:0] m_tdata;
    logic         m_tuser;
    int           fail_count;
    int           pending;
    int           burst_left;
    logic         hold_go;

    sphere_air_drag_force_torque u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    sadf_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'h7fff_ffff;
            2: return 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
        endcase
    endfunction

    function automatic logic [30:0] rand_radius();
        if ($urandom_range(0, 9) == 0)
            return 31'($urandom);
        return 31'($urandom_range(0, 1 << 18));
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
    endtask

    task automatic set_config(input logic [31:0] vis, input logic [31:0] den,
                              input logic [31:0] wx, input logic [31:0] wy,
                              input logic [31:0] wz, input logic [31:0] gs,
                              input logic re);
        write_reg(REG_VISCOSITY, vis);
        write_reg(REG_DENSITY, den);
        write_reg(REG_WIND_X, wx);
        write_reg(REG_WIND_Y, wy);
        write_reg(REG_WIND_Z, wz);
        write_reg(REG_GROUP_SELECT, gs);
        write_reg(REG_REGION_ENABLE, {31'd0, re});
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // one beat: vel xyz, spin xyz, radius, group bits
    task automatic send_particle(input logic [31:0] v [3], input logic [31:0] w [3],
                                 input logic [30:0] rad, input logic [31:0] grp,
                                 input logic inreg);
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 10);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, grp, rad, w[2], w[1], w[0], v[2], v[1], v[0]};
        s_tuser <= inreg;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic send_random(input int count);
        logic [31:0] v [3];
        logic [31:0] w [3];
        for (int n = 0; n < count; n++)
        begin
            foreach (v[i])
            begin
                v[i] = rand_word();
                w[i] = rand_word();
            end
            send_particle(v, w, rand_radius(),
                          ($urandom_range(0, 3) == 0) ? $urandom : (32'd1 << $urandom_range(0, 31)),
                          $urandom_range(0, 1));
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    initial
    begin
        logic [31:0] v [3];
        logic [31:0] w [3];
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        burst_left = 0;
        hold_go = 1'b0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: nothing selected
        send_random(5);
        drain();

        set_config(32'h0001_0000, 32'h0001_0000, 32'h0003_0000, 32'hfffe_0000, 32'd0,
                   32'hffff_ffff, 1'b0);
        v = '{32'd0, 32'd0, 32'd0};
        w = '{32'd0, 32'd0, 32'd0};
        send_particle(v, w, 31'h0001_0000, 32'h1, 1'b0);
        send_particle(v, w, 31'd0, 32'h8000_0000, 1'b1);
        v = '{32'h7fff_ffff, 32'h8000_0000, 32'h0003_0000};
        w = '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff};
        send_particle(v, w, 31'h7fff_ffff, 32'hffff_ffff, 1'b1);
        send_particle(v, w, 31'h0000_8000, 32'h0000_0001, 1'b0);
        v = '{32'h0001_0000, 32'hffff_0000, 32'd5};
        w = '{32'hffff_ffff, 32'd1, 32'd0};
        send_particle(v, w, 31'h0002_0000, 32'h0001_0000, 1'b0);
        send_particle(v, w, 31'h7fff_ffff, 32'h0, 1'b1);
        drain();

        set_config(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                   32'h0000_0001, 1'b1);
        v = '{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000};
        w = '{32'h7fff_ffff, 32'h8000_0000, 32'h0};
        send_particle(v, w, 31'h7fff_ffff, 32'h0000_0001, 1'b1);
        send_particle(v, w, 31'h7fff_ffff, 32'h0000_0001, 1'b0);
        send_particle(v, w, 31'd1, 32'hffff_fffe, 1'b1);
        v = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff};
        send_particle(v, w, 31'd1, 32'h0000_0003, 1'b1);
        send_particle(v, w, 31'h0000_0100, 32'hffff_ffff, 1'b1);
        hold_go = 1'b1;
        send_random(60);
        drain();

        set_config(32'h0, 32'h0, 32'h8000_0000, 32'h0, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
        send_random(60);
        drain();

        repeat (5)
        begin
            set_config($urandom_range(0, 1 << 18), $urandom_range(0, 1 << 20), rand_word(),
                       rand_word(), rand_word(), $urandom | (32'd1 << $urandom_range(0, 31)),
                       $urandom_range(0, 1));
            send_random(56);
            drain();
        end

        if (fail_count == 0)
            $display("sphere_air_drag_force_torque verification clean");
        else
            $display("sphere_air_drag_force_torque verification failed");
        $finish;
    end

    // output stalls; one long hold-off while the sender keeps offering beats
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        while (!hold_go)
        begin
            @(posedge clk);
            m_tready <= $urandom_range(0, 3) != 0;
        end
        @(posedge clk);
        m_tready <= 1'b0;
        repeat (250) @(posedge clk);
        forever
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    @(posedge clk);
                    m_tready <= 1'b1;
                    repeat ($urandom_range(10, 60)) @(posedge clk);
                end
                1:
                begin
                    @(posedge clk);
                    m_tready <= 1'b0;
                    repeat ($urandom_range(1, 12)) @(posedge clk);
                end
                default:
                begin
                    @(posedge clk);
                    m_tready <= $urandom_range(0, 1);
                end
            endcase
        end
    end

    initial
    begin
        #(8 * 300000);
        $display("sphere_air_drag_force_torque verification failed");
        $finish;
    end

endmodule
